@@ sv/ttcg_pkg.sv @@
// Package for the text-to-character-grid unit.
// Holds the result item type, register addresses, character codes and defaults.
// No dependencies.
package ttcg_pkg;

    localparam int DEF_MAX_COLUMNS = 80;
    localparam int DEF_MAX_ROWS    = 36;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [6:0] COLUMN_COUNT_RESET = 7'd80;
    localparam logic [5:0] ROW_COUNT_RESET    = 6'd23;

    localparam logic [6:0] CHR_TAB     = 7'h09;
    localparam logic [6:0] CHR_NL      = 7'h0A;
    localparam logic [6:0] CHR_CARET   = 7'h5E;
    localparam logic [6:0] CHR_DEL     = 7'h7F;
    localparam logic [6:0] CHR_SPACE   = 7'h20;
    localparam logic [6:0] CARET_SHIFT = 7'h40;

    typedef enum logic
    {
        REG_COLUMN_COUNT = 1'b0,
        REG_ROW_COUNT    = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic       write_valid;
        logic [5:0] cell_row;
        logic [6:0] cell_column;
        logic [6:0] cell_char;
        logic       screen_full;
        logic       last_result;
    } result_t;

    typedef struct packed
    {
        logic       two;
        result_t    res0;
        result_t    res1;
    } step_out_t;

endpackage

@@ sv/ttcg_regs.sv @@
// Configuration registers of the text-to-character-grid unit behind an APB-style port.
// Depends on ttcg_pkg.
module ttcg_regs
    import ttcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [6:0]        column_count,
    output logic [5:0]        row_count
);

    logic       wr_en;
    reg_index_t index;
    logic [6:0] column_count_reg;
    logic [5:0] row_count_reg;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RESET;
            row_count_reg    <= ROW_COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_COLUMN_COUNT: column_count_reg <= pwdata[6:0];
                REG_ROW_COUNT:    row_count_reg    <= pwdata[5:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_COLUMN_COUNT: prdata = {{(DATA_W-7){1'b0}}, column_count_reg};
            REG_ROW_COUNT:    prdata = {{(DATA_W-6){1'b0}}, row_count_reg};
            default:          prdata = '0;
        endcase
    end

    assign column_count = column_count_reg;
    assign row_count    = row_count_reg;

endmodule

@@ sv/ttcg_step.sv @@
// Position update and cell write generation for one text byte.
// Depends on ttcg_pkg.
module ttcg_step
    import ttcg_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  logic [7:0] text_byte,
    input  logic       new_screen,
    input  logic [6:0] column_count,
    input  logic [5:0] row_count,
    input  logic [5:0] cur_row,
    input  logic [6:0] cur_column,
    input  logic       full_flag,
    output logic [5:0] row_next,
    output logic [6:0] column_next,
    output logic       full_next,
    output step_out_t  step_out
);

    localparam logic [7:0] MAX_CO = 8'(MAX_COLUMNS);
    localparam logic [7:0] MAX_LI = 8'(MAX_ROWS - 1);

    logic [7:0] co;
    logic [7:0] li;
    logic [7:0] row;
    logic [7:0] col;
    logic       full;
    logic [6:0] chr;
    logic       w0;
    logic       w1;
    logic [7:0] row0;
    logic [7:0] col0;
    logic [6:0] chr0;
    logic [7:0] row1;
    logic [7:0] col1;
    logic [6:0] chr1;

    always_comb
    begin
        co   = {1'b0, column_count};
        li   = {2'b0, row_count};
        row  = new_screen ? 8'd0 : {2'b0, cur_row};
        col  = new_screen ? 8'd0 : {1'b0, cur_column};
        full = new_screen ? 1'b0 : full_flag;
        chr  = text_byte[6:0];
        w0   = 1'b0;
        w1   = 1'b0;
        row0 = '0;
        col0 = '0;
        chr0 = '0;
        row1 = '0;
        col1 = '0;
        chr1 = '0;

        if (co == 8'd0)
            co = 8'd1;
        if (co > MAX_CO)
            co = MAX_CO;
        if (li == 8'd0)
            li = 8'd1;
        if (li > MAX_LI)
            li = MAX_LI;

        if (col >= co)
        begin
            col = 8'd0;
            row = row + 8'd1;
        end
        if (row >= li)
        begin
            full = 1'b1;
            row  = li;
        end

        if (!full && text_byte != 8'd0)
        begin
            if (chr < CHR_SPACE || chr == CHR_DEL)
            begin
                if (chr == CHR_TAB)
                    col = (col | 8'd7) + 8'd1;
                else if (chr == CHR_NL)
                begin
                    col = 8'd0;
                    row = row + 8'd1;
                end
                else
                begin
                    w0   = 1'b1;
                    row0 = row;
                    col0 = col;
                    chr0 = CHR_CARET;
                    col  = col + 8'd1;
                    if (col >= co)
                    begin
                        col = col - co;
                        row = row + 8'd1;
                    end
                    w1   = 1'b1;
                    row1 = row;
                    col1 = col;
                    chr1 = chr + CARET_SHIFT;
                    col  = col + 8'd1;
                end
            end
            else
            begin
                w0   = 1'b1;
                row0 = row;
                col0 = col;
                chr0 = chr;
                col  = col + 8'd1;
            end
            if (col >= co)
            begin
                col = col - co;
                row = row + 8'd1;
                if (col >= co)
                    col = 8'd0;
            end
            if (row >= li)
            begin
                full = 1'b1;
                row  = li;
            end
        end

        row_next    = row[5:0];
        column_next = col[6:0];
        full_next   = full;

        step_out.two                  = w1;
        step_out.res0.write_valid     = w0;
        step_out.res0.cell_row        = row0[5:0];
        step_out.res0.cell_column     = col0[6:0];
        step_out.res0.cell_char       = chr0;
        step_out.res0.screen_full     = full;
        step_out.res0.last_result     = !w1;
        step_out.res1.write_valid     = 1'b1;
        step_out.res1.cell_row        = row1[5:0];
        step_out.res1.cell_column     = col1[6:0];
        step_out.res1.cell_char       = chr1;
        step_out.res1.screen_full     = full;
        step_out.res1.last_result     = 1'b1;
    end

endmodule

@@ sv/ttcg_resq.sv @@
// Four-entry result queue; takes one or two result items per push.
// Depends on ttcg_pkg.
module ttcg_resq
    import ttcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_out_t push_data,
    output logic      room,
    output logic      out_valid,
    input  logic      out_stall,
    output result_t   out_data,
    output logic [2:0] count
);

    result_t    mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_next;
    logic       pop;
    logic [2:0] push_n;

    assign pop       = out_valid && !out_stall;
    assign out_valid = count_reg != 3'd0;
    assign out_data  = mem[rd_ptr_reg];
    assign room      = (count_reg <= 3'd2) || (count_reg == 3'd3 && pop);
    assign count     = count_reg;
    assign push_n    = push ? (push_data.two ? 3'd2 : 3'd1) : 3'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + push_n - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data.res0;
            if (push_data.two)
                mem[wr_ptr_reg + 2'd1] <= push_data.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/text_to_character_grid_unit.sv @@
// Top level of the text-to-character-grid unit: input register, position state,
// step logic and result queue. Depends on ttcg_pkg, ttcg_regs, ttcg_step, ttcg_resq.
//
// Lays a byte stream into a character grid and issues one or two cell-write items
// per byte (two for caret notation). A byte is registered on acceptance and
// processed once the result queue has room; the position update of one short
// combinational step moves its one or two results into a four-entry result queue.
// One byte can be taken every cycle while the queue has room; results leave the
// queue one at a time, so bytes that expand into two results limit the sustained
// input rate. A byte's results pass through the input register and the queue.
module text_to_character_grid_unit
    import ttcg_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        text_byte,
    input  logic              new_screen,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              write_valid,
    output logic [5:0]        cell_row,
    output logic [6:0]        cell_column,
    output logic [6:0]        cell_char,
    output logic              screen_full,
    output logic              last_result
);

    logic [6:0] column_count;
    logic [5:0] row_count;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] text_byte_reg;
    logic       new_screen_reg;

    logic [5:0] cur_row_reg;
    logic [6:0] cur_column_reg;
    logic       full_flag_reg;
    logic [5:0] cur_row_next;
    logic [6:0] cur_column_next;
    logic       full_flag_next;

    step_out_t  step_out;
    result_t    out_data;
    logic       room;
    logic       fire;
    logic       accept;
    logic [2:0] q_count;

    ttcg_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .column_count (column_count),
        .row_count    (row_count)
    );

    ttcg_step #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_step
    (
        .text_byte    (text_byte_reg),
        .new_screen   (new_screen_reg),
        .column_count (column_count),
        .row_count    (row_count),
        .cur_row      (cur_row_reg),
        .cur_column   (cur_column_reg),
        .full_flag    (full_flag_reg),
        .row_next     (cur_row_next),
        .column_next  (cur_column_next),
        .full_next    (full_flag_next),
        .step_out     (step_out)
    );

    ttcg_resq u_resq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (step_out),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .count     (q_count)
    );

    assign fire          = in_valid_reg && room;
    assign in_stall      = in_valid_reg && !room;
    assign accept        = in_valid && !in_stall;
    assign in_valid_next = accept || (in_valid_reg && !fire);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            text_byte_reg  <= text_byte;
            new_screen_reg <= new_screen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            cur_row_reg    <= '0;
            cur_column_reg <= '0;
            full_flag_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                cur_row_reg    <= cur_row_next;
                cur_column_reg <= cur_column_next;
                full_flag_reg  <= full_flag_next;
            end
        end
    end

    assign write_valid = out_data.write_valid;
    assign cell_row    = out_data.cell_row;
    assign cell_column = out_data.cell_column;
    assign cell_char   = out_data.cell_char;
    assign screen_full = out_data.screen_full;
    assign last_result = out_data.last_result;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 3'd4)
        else $error("result queue overflow");

    a_full_row: assert property (@(posedge clk) disable iff (!rst_n)
        full_flag_reg |-> cur_row_reg != 6'd0)
        else $error("full flag set with row zero");

    a_nowrite_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> last_result)
        else $error("empty result not marked last");

    a_fire_pops_input: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !in_valid |=> !in_valid_reg)
        else $error("input register kept after processing");

endmodule

@@ tb/sv/text_to_character_grid_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for text_to_character_grid_unit: directed script, then random text phases
// under several register settings, checked against a grid position predictor.
// Depends on ttcg_pkg and the text_to_character_grid_unit RTL.
module text_to_character_grid_unit_tb;
    import ttcg_pkg::*;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_ITEMS     = 85;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 10;
    localparam int SETTLE_CYCLES   = 4;

    typedef enum logic [1:0]
    {
        ROW_ITEM,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct
    {
        row_kind_t   kind;
        logic [7:0]  raw;
        logic        ns;
        reg_index_t  idx;
        logic [31:0] val;
        result_t     e0;
        result_t     e1;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        text_byte = 8'h00;
    logic              new_screen = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              write_valid;
    logic [5:0]        cell_row;
    logic [6:0]        cell_column;
    logic [6:0]        cell_char;
    logic              screen_full;
    logic              last_result;

    text_to_character_grid_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .new_screen  (new_screen),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .cell_char   (cell_char),
        .screen_full (screen_full),
        .last_result (last_result)
    );

    // grid position and register mirror
    logic [5:0]  pos_row = '0;
    logic [6:0]  pos_col = '0;
    logic        pos_full = 1'b0;
    logic [6:0]  reg_cols = COLUMN_COUNT_RESET;
    logic [5:0]  reg_rows = ROW_COUNT_RESET;

    result_t     pending_cells[$];
    script_row_t script[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          sender_idle_pct = 38;
    int          recv_idle_pct = 65;
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    result_t     got_cell;
    result_t     want_cell;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t make_cell(input logic wv, input logic [5:0] row,
                                          input logic [6:0] col, input logic [6:0] ch,
                                          input logic full, input logic last);
        return {wv, row, col, ch, full, last};
    endfunction

    function automatic int advance_grid(input logic [7:0] raw, input logic ns,
                                        output result_t r0, output result_t r1);
        int co;
        int li;
        int row;
        int col;
        int c;
        int n;
        int wrow[2];
        int wcol[2];
        int wchr[2];
        n = 0;
        wrow = '{0, 0};
        wcol = '{0, 0};
        wchr = '{0, 0};
        if (ns)
        begin
            pos_row = '0;
            pos_col = '0;
            pos_full = 1'b0;
        end
        co = (reg_cols == 0) ? 1 : (int'(reg_cols) > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
                                                                      : int'(reg_cols);
        li = (reg_rows == 0) ? 1 : (int'(reg_rows) > DEF_MAX_ROWS - 1) ? DEF_MAX_ROWS - 1
                                                                       : int'(reg_rows);
        row = pos_row;
        col = pos_col;
        if (col >= co)
        begin
            col = 0;
            row++;
        end
        if (row >= li)
        begin
            pos_full = 1'b1;
            row = li;
        end
        if (!pos_full && raw != 8'h00)
        begin
            c = raw[6:0];
            if (c < 32 || c == CHR_DEL)
            begin
                if (c == CHR_TAB)
                    col = (col | 7) + 1;
                else if (c == CHR_NL)
                begin
                    col = 0;
                    row++;
                end
                else
                begin
                    wrow[0] = row;
                    wcol[0] = col;
                    wchr[0] = CHR_CARET;
                    col++;
                    if (col >= co)
                    begin
                        col -= co;
                        row++;
                    end
                    wrow[1] = row;
                    wcol[1] = col;
                    wchr[1] = (c + CARET_SHIFT) & 127;
                    n = 2;
                    col++;
                end
            end
            else
            begin
                wrow[0] = row;
                wcol[0] = col;
                wchr[0] = c;
                n = 1;
                col++;
            end
            if (col >= co)
            begin
                col -= co;
                row++;
                if (col >= co)
                    col = 0;
            end
            if (row >= li)
            begin
                pos_full = 1'b1;
                row = li;
            end
        end
        pos_row = 6'(row);
        pos_col = 7'(col);
        if (n == 0)
        begin
            r0 = make_cell(1'b0, 6'd0, 7'd0, 7'd0, pos_full, 1'b1);
            r1 = '0;
            return 1;
        end
        r0 = make_cell(1'b1, 6'(wrow[0]), 7'(wcol[0]), 7'(wchr[0]), pos_full, n == 1);
        r1 = make_cell(1'b1, 6'(wrow[1]), 7'(wcol[1]), 7'(wchr[1]), pos_full, 1'b1);
        return n;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int roll;
        logic [7:0] b;
        roll = $urandom_range(0, 99);
        if (roll < 62)
            b = 8'($urandom_range(32, 126));
        else if (roll < 72)
            b = {1'b0, CHR_NL};
        else if (roll < 78)
            b = {1'b0, CHR_TAB};
        else if (roll < 88)
            b = ($urandom_range(0, 7) == 0) ? {1'b0, CHR_DEL} : 8'($urandom_range(1, 31));
        else if (roll < 91)
            b = 8'h00;
        else
            b = 8'($urandom_range(0, 255));
        if (b != 8'h00 && $urandom_range(0, 9) == 0)
            b[7] = 1'b1;
        return b;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [7:0] raw, input logic ns,
                           input result_t e0 = '0, input result_t e1 = '0);
        script_row_t r;
        r.kind = kind;
        r.raw = raw;
        r.ns = ns;
        r.idx = REG_COLUMN_COUNT;
        r.val = '0;
        r.e0 = e0;
        r.e1 = e1;
        script.push_back(r);
    endtask

    task automatic add_cfg(input reg_index_t idx, input logic [31:0] val);
        script_row_t r;
        r.kind = ROW_CFG;
        r.raw = 8'h00;
        r.ns = 1'b0;
        r.idx = idx;
        r.val = val;
        r.e0 = '0;
        r.e1 = '0;
        script.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        if (mismatch_count < 10)
            $display("mismatch (%s) at cycle %0d: ", what, cycle_count,
                     "expected wv=%0d row=%0d col=%0d chr=%h full=%0d last=%0d, ",
                     want.write_valid, want.cell_row, want.cell_column, want.cell_char,
                     want.screen_full, want.last_result,
                     "got wv=%0d row=%0d col=%0d chr=%h full=%0d last=%0d",
                     got.write_valid, got.cell_row, got.cell_column, got.cell_char,
                     got.screen_full, got.last_result);
        mismatch_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COLUMN_COUNT: reg_cols = val[6:0];
            REG_ROW_COUNT:    reg_rows = val[5:0];
            default:          ;
        endcase
    endtask

    task automatic send_item(input logic [7:0] raw, input logic ns, input logic typed,
                             input result_t e0, input result_t e1);
        result_t p0;
        result_t p1;
        int n;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= raw;
        new_screen <= ns;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = advance_grid(raw, ns, p0, p1);
        if (typed)
        begin
            pending_cells.push_back(e0);
            if (!e0.last_result)
                pending_cells.push_back(e1);
        end
        else
        begin
            pending_cells.push_back(p0);
            if (n == 2)
                pending_cells.push_back(p1);
        end
    endtask

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_cell = {write_valid, cell_row, cell_column, cell_char, screen_full, last_result};
            if (pending_cells.size() == 0)
                note_mismatch("unexpected", '0, got_cell);
            else
            begin
                want_cell = pending_cells.pop_front();
                if (got_cell.write_valid !== want_cell.write_valid ||
                    got_cell.cell_row !== want_cell.cell_row ||
                    got_cell.cell_column !== want_cell.cell_column ||
                    got_cell.cell_char !== want_cell.cell_char ||
                    got_cell.screen_full !== want_cell.screen_full ||
                    got_cell.last_result !== want_cell.last_result)
                    note_mismatch("field", want_cell, got_cell);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [6:0] phase_cols[PHASE_COUNT];
        logic [5:0] phase_rows[PHASE_COUNT];
        int g;
        logic noise;
        logic [7:0] raw;
        logic ns;
        phase_cols = '{7'd80, 7'd5, 7'd0, 7'd127, 7'd1, 7'd17};
        phase_rows = '{6'd23, 6'd3, 6'd0, 6'd63, 6'd35, 6'd6};
        g = 0;

        // reset defaults: 80 columns, 23 rows
        add_row(ROW_TYPED, 8'h41, 1'b1, make_cell(1'b1, 6'd0, 7'd0, 7'h41, 1'b0, 1'b1));
        add_row(ROW_TYPED, 8'h00, 1'b0, make_cell(1'b0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1));
        add_row(ROW_TYPED, 8'h80, 1'b0,
                make_cell(1'b1, 6'd0, 7'd1, CHR_CARET, 1'b0, 1'b0),
                make_cell(1'b1, 6'd0, 7'd2, 7'h40, 1'b0, 1'b1));
        add_row(ROW_TYPED, 8'h09, 1'b0, make_cell(1'b0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1));
        add_row(ROW_TYPED, 8'h0A, 1'b0, make_cell(1'b0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1));
        add_row(ROW_TYPED, 8'h7F, 1'b0,
                make_cell(1'b1, 6'd1, 7'd0, CHR_CARET, 1'b0, 1'b0),
                make_cell(1'b1, 6'd1, 7'd1, 7'h3F, 1'b0, 1'b1));
        add_row(ROW_ITEM, 8'hFF, 1'b0);
        add_row(ROW_ITEM, 8'h7E, 1'b0);
        add_row(ROW_ITEM, 8'hC1, 1'b0);
        add_row(ROW_ITEM, 8'h01, 1'b0);
        add_row(ROW_ITEM, 8'h1F, 1'b0);
        add_row(ROW_ITEM, 8'h8A, 1'b0);
        add_row(ROW_ITEM, 8'h89, 1'b0);
        // caret wrapping onto the last row, then an ignored byte
        add_cfg(REG_COLUMN_COUNT, 32'd2);
        add_cfg(REG_ROW_COUNT, 32'd2);
        add_row(ROW_ITEM, 8'h0A, 1'b1);
        add_row(ROW_ITEM, 8'h78, 1'b0);
        add_row(ROW_ITEM, 8'h02, 1'b0);
        add_row(ROW_TYPED, 8'h79, 1'b0, make_cell(1'b0, 6'd0, 7'd0, 7'd0, 1'b1, 1'b1));
        // tab past the edge
        add_cfg(REG_COLUMN_COUNT, 32'd3);
        add_cfg(REG_ROW_COUNT, 32'd35);
        add_row(ROW_ITEM, 8'h09, 1'b1);
        add_row(ROW_ITEM, 8'h7A, 1'b0);
        // zero registers count as one
        add_cfg(REG_COLUMN_COUNT, 32'd0);
        add_cfg(REG_ROW_COUNT, 32'd0);
        add_row(ROW_TYPED, 8'h61, 1'b1, make_cell(1'b1, 6'd0, 7'd0, 7'h61, 1'b1, 1'b1));
        // oversize registers, then stale position after shrinking
        add_cfg(REG_COLUMN_COUNT, 32'd127);
        add_cfg(REG_ROW_COUNT, 32'd63);
        add_row(ROW_ITEM, 8'h0A, 1'b1);
        add_row(ROW_ITEM, 8'h0A, 1'b0);
        add_row(ROW_ITEM, 8'h61, 1'b0);
        add_cfg(REG_COLUMN_COUNT, 32'd1);
        add_cfg(REG_ROW_COUNT, 32'd2);
        add_row(ROW_TYPED, 8'h62, 1'b0, make_cell(1'b0, 6'd0, 7'd0, 7'd0, 1'b1, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(script[i].idx, script[i].val);
            end
            else
                send_item(script[i].raw, script[i].ns, script[i].kind == ROW_TYPED,
                          script[i].e0, script[i].e1);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            write_reg(REG_COLUMN_COUNT, 32'(phase_cols[p]));
            write_reg(REG_ROW_COUNT, 32'(phase_rows[p]));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (g < 170)
                begin
                    sender_idle_pct = 38;
                    recv_idle_pct = 65;
                end
                else if (g < 340)
                begin
                    sender_idle_pct = 65;
                    recv_idle_pct = 38;
                end
                else
                begin
                    sender_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (p == 1 && i == 10)
                    hold_go <= ~hold_go;
                if (p == 3 && i == 40)
                    drain_results();
                noise = ($urandom_range(0, 9) == 0);
                if (noise)
                begin
                    raw = 8'($urandom_range(0, 255));
                    ns = 1'($urandom_range(0, 1));
                end
                else
                begin
                    raw = pick_text_byte();
                    ns = (i == 0) || ($urandom_range(0, 99) < 8);
                end
                send_item(raw, ns, 1'b0, '0, '0);
                g++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_cells.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
